[rtl/dpgc_pkg.sv]
// Package: shared widths, register indexes, sideband type and colour ramp function.
package dpgc_pkg;
   localparam int CoordW    = 24;
   localparam int SquareW   = 48;
   localparam int RootW     = 24;
   localparam int DepthMmW  = 16;
   localparam int FracW     = 8;
   localparam int GrayW     = 16;
   localparam int NumW      = 40;
   localparam int SpanW     = 24;
   localparam int SqrtStages = RootW;
   localparam int DivStages  = GrayW;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 24;

   localparam logic [CsrIdxW-1:0] CsrMinDepth   = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrMaxDepth   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrRadialMode = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrInvalidNan = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrInvalidZ   = 3'd4;

   localparam logic [DepthMmW-1:0] MaxDepthReset = 16'd600;
   localparam logic [GrayW-1:0]    GrayFull      = 16'hFFFF;

   typedef struct packed {
      logic                     ok;
      logic signed [CoordW-1:0] z;
   } dpgc_side_type;

   // Returns {blue, green, red} of the four-segment ramp.
   function automatic logic [23:0] dpgc_ramp(input logic [GrayW-1:0] gray);
      logic [7:0]  val;
      logic [23:0] res;
      val = gray[13:6];
      res = {8'h00, val, 8'hFF};
      if (gray[14]) begin
         res = {8'h00, 8'hFF, ~val};
      end
      if (gray[15]) begin
         res = {res[15:0], 8'h00};
      end
      return res;
   endfunction
endpackage

[rtl/depth_point_to_gray_and_color.sv]
// Top level: depth point to 16-bit gray value and blue/green/red colour ramp.
//
// Input channel req_*: one camera point per item (x, y, z in 1/256 mm and a NaN
// flag for z). Result channel rsp_*: one item per point with gray depth, the
// three colour bytes and a pixel valid flag. Both use valid/ready.
// Configuration: csr_we with csr_index and csr_data writes one register per
// cycle; write only while no item is in flight.
//
// The block is a single stall-together pipeline: squares, sum, 24 square root
// stages (one root bit each), clip, scale multiply, 16 divider stages (one
// quotient bit each) and the output register. One item is accepted per cycle,
// in both depth modes, while no result waits on a stalled receiver.
//
// Reset clears every valid bit and loads the register reset values
// (max depth 600 mm, everything else 0). When the receiver stalls with a
// result waiting, the whole pipeline holds and req_ready drops in the same
// cycle; no item is dropped or repeated, and bubbles in the pipe still move
// while the output register is empty.
module depth_point_to_gray_and_color (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [dpgc_pkg::CoordW-1:0]   req_coord_x,
   input  logic signed [dpgc_pkg::CoordW-1:0]   req_coord_y,
   input  logic signed [dpgc_pkg::CoordW-1:0]   req_coord_z,
   input  logic                                 req_z_is_nan,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dpgc_pkg::GrayW-1:0]           rsp_gray_depth,
   output logic [7:0]                           rsp_blue_level,
   output logic [7:0]                           rsp_green_level,
   output logic [7:0]                           rsp_red_level,
   output logic                                 rsp_pixel_valid,
   input  logic                                 csr_we,
   input  logic [dpgc_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [dpgc_pkg::CsrDataW-1:0]        csr_data
);
   import dpgc_pkg::*;

   // Configuration registers
   logic [DepthMmW-1:0]      min_mm_ff;
   logic [DepthMmW-1:0]      max_mm_ff;
   logic                     radial_ff;
   logic                     inv_nan_ff;
   logic signed [CoordW-1:0] inv_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mm_ff  <= '0;
         max_mm_ff  <= MaxDepthReset;
         radial_ff  <= 1'b0;
         inv_nan_ff <= 1'b0;
         inv_z_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrMinDepth:   min_mm_ff  <= csr_data[DepthMmW-1:0];
            CsrMaxDepth:   max_mm_ff  <= csr_data[DepthMmW-1:0];
            CsrRadialMode: radial_ff  <= csr_data[0];
            CsrInvalidNan: inv_nan_ff <= csr_data[0];
            CsrInvalidZ:   inv_z_ff   <= csr_data[CoordW-1:0];
            default: ;
         endcase
      end
   end

   // Advance the whole pipe unless a result waits on a stalled receiver
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Stage 1: validity check and squares of the magnitudes
   logic                 ok_in;
   logic [CoordW-1:0]    ax, ay, az;
   logic                 v1_ff;
   dpgc_side_type        side1_ff;
   logic [SquareW-1:0]   sqx_ff, sqy_ff, sqz_ff;

   always_comb begin
      if (req_z_is_nan) begin
         ok_in = 1'b0;
      end else if (inv_nan_ff) begin
         ok_in = 1'b1;
      end else begin
         ok_in = (req_coord_z != inv_z_ff);
      end
      ax = req_coord_x[CoordW-1] ? CoordW'(-req_coord_x) : req_coord_x;
      ay = req_coord_y[CoordW-1] ? CoordW'(-req_coord_y) : req_coord_y;
      az = req_coord_z[CoordW-1] ? CoordW'(-req_coord_z) : req_coord_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         side1_ff.ok <= ok_in;
         side1_ff.z  <= req_coord_z;
         sqx_ff      <= SquareW'(ax) * SquareW'(ax);
         sqy_ff      <= SquareW'(ay) * SquareW'(ay);
         sqz_ff      <= SquareW'(az) * SquareW'(az);
      end
   end

   // Stage 2: sum of squares (at most 3 * 2^46, fits 48 bits)
   logic               v2_ff;
   dpgc_side_type      side2_ff;
   logic [SquareW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         side2_ff <= side1_ff;
         sum_ff   <= sqx_ff + sqy_ff + sqz_ff;
      end
   end

   // Square root pipe
   logic            v3;
   logic [RootW-1:0] root3;
   dpgc_side_type   side3;

   dpgc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_n      (sum_ff),
      .in_side   (side2_ff),
      .out_valid (v3),
      .out_root  (root3),
      .out_side  (side3)
   );

   // Stage 4: pick depth, clip to range, offset from the minimum
   logic signed [CoordW:0] depth, lo, hi, clipped;
   logic [SpanW-1:0]       dd_in, span_in;
   logic                   v4_ff, ok4_ff;
   logic [SpanW-1:0]       dd_ff, span4_ff;

   always_comb begin
      depth = radial_ff ? $signed({1'b0, root3}) : $signed({side3.z[CoordW-1], side3.z});
      lo    = $signed({1'b0, min_mm_ff, {FracW{1'b0}}});
      hi    = $signed({1'b0, max_mm_ff, {FracW{1'b0}}});
      if (depth < lo) begin
         clipped = lo;
      end else if (depth > hi) begin
         clipped = hi;
      end else begin
         clipped = depth;
      end
      dd_in   = SpanW'(clipped - lo);
      span_in = SpanW'(hi - lo);
      // Empty range: force a zero quotient
      if (max_mm_ff <= min_mm_ff) begin
         dd_in   = '0;
         span_in = SpanW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3;
      end
      if (en) begin
         ok4_ff   <= side3.ok;
         dd_ff    <= dd_in;
         span4_ff <= span_in;
      end
   end

   // Stage 5: scale by full gray range
   logic             v5_ff, ok5_ff;
   logic [NumW-1:0]  num5_ff;
   logic [SpanW-1:0] span5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         ok5_ff   <= ok4_ff;
         num5_ff  <= NumW'(dd_ff) * NumW'(GrayFull);
         span5_ff <= span4_ff;
      end
   end

   // Divider pipe: quotient stays below 2^16 since dd <= span
   logic             v6, ok6;
   logic [GrayW-1:0] gray6;

   dpgc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_num    (num5_ff),
      .in_den    (span5_ff),
      .in_ok     (ok5_ff),
      .out_valid (v6),
      .out_quot  (gray6),
      .out_ok    (ok6)
   );

   // Output register: colour ramp, blank invalid pixels
   logic [23:0] bgr;
   assign bgr = dpgc_ramp(gray6);

   logic             rsp_valid_ff;
   logic [GrayW-1:0] gray_ff;
   logic [7:0]       blue_ff, green_ff, red_ff;
   logic             pix_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v6;
      end
      if (en) begin
         pix_ok_ff <= ok6;
         gray_ff   <= ok6 ? gray6 : '0;
         blue_ff   <= ok6 ? bgr[23:16] : 8'h00;
         green_ff  <= ok6 ? bgr[15:8] : 8'h00;
         red_ff    <= ok6 ? bgr[7:0] : 8'h00;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gray_depth  = gray_ff;
   assign rsp_blue_level  = blue_ff;
   assign rsp_green_level = green_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_pixel_valid = pix_ok_ff;
endmodule

[rtl/dpgc_sqrt.sv]
// Pipelined integer square root, one root bit per stage, sideband carried along.
module dpgc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [dpgc_pkg::SquareW-1:0]  in_n,
   input  dpgc_pkg::dpgc_side_type       in_side,
   output logic                          out_valid,
   output logic [dpgc_pkg::RootW-1:0]    out_root,
   output dpgc_pkg::dpgc_side_type       out_side
);
   import dpgc_pkg::*;

   logic [SquareW-1:0] rem_ff  [SqrtStages];
   logic [RootW-1:0]   root_ff [SqrtStages];
   dpgc_side_type      side_ff [SqrtStages];
   logic [SqrtStages-1:0] valid_ff;

   genvar s;
   for (s = 0; s < SqrtStages; s++) begin : g_stage
      localparam int Bit = SqrtStages - 1 - s;
      logic [SquareW-1:0] rem_src;
      logic [RootW-1:0]   root_src;
      dpgc_side_type      side_src;
      logic               valid_src;
      logic [SquareW-1:0] trial;
      logic [SquareW-1:0] rem_in;
      logic [RootW-1:0]   root_in;

      if (s == 0) begin : g_first
         assign rem_src   = in_n;
         assign root_src  = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[s-1];
         assign root_src  = root_ff[s-1];
         assign side_src  = side_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      // Try setting this root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 4^b.
      always_comb begin
         trial = ({{(SquareW-RootW){1'b0}}, root_src} << (Bit + 1))
               + (SquareW'(1) << (2 * Bit));
         rem_in  = rem_src;
         root_in = root_src;
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (RootW'(1) << Bit);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[SqrtStages-1];
   assign out_root  = root_ff[SqrtStages-1];
   assign out_side  = side_ff[SqrtStages-1];
endmodule

[rtl/dpgc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module dpgc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [dpgc_pkg::NumW-1:0]   in_num,
   input  logic [dpgc_pkg::SpanW-1:0]  in_den,
   input  logic                        in_ok,
   output logic                        out_valid,
   output logic [dpgc_pkg::GrayW-1:0]  out_quot,
   output logic                        out_ok
);
   import dpgc_pkg::*;

   logic [NumW-1:0]  num_ff  [DivStages];
   logic [SpanW-1:0] den_ff  [DivStages];
   logic [GrayW-1:0] quot_ff [DivStages];
   logic [DivStages-1:0] ok_ff;
   logic [DivStages-1:0] valid_ff;

   genvar s;
   for (s = 0; s < DivStages; s++) begin : g_stage
      localparam int Bit = DivStages - 1 - s;
      logic [NumW-1:0]  num_src;
      logic [SpanW-1:0] den_src;
      logic [GrayW-1:0] quot_src;
      logic             ok_src;
      logic             valid_src;
      logic [NumW-1:0]  shifted;
      logic [NumW-1:0]  num_in;
      logic [GrayW-1:0] quot_in;

      if (s == 0) begin : g_first
         assign num_src   = in_num;
         assign den_src   = in_den;
         assign quot_src  = '0;
         assign ok_src    = in_ok;
         assign valid_src = in_valid;
      end else begin : g_next
         assign num_src   = num_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign quot_src  = quot_ff[s-1];
         assign ok_src    = ok_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      always_comb begin
         shifted = {{(NumW-SpanW){1'b0}}, den_src} << Bit;
         num_in  = num_src;
         quot_in = quot_src;
         if (num_src >= shifted) begin
            num_in  = num_src - shifted;
            quot_in = quot_src | (GrayW'(1) << Bit);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
         if (en) begin
            num_ff[s]  <= num_in;
            den_ff[s]  <= den_src;
            quot_ff[s] <= quot_in;
            ok_ff[s]   <= ok_src;
         end
      end
   end

   assign out_valid = valid_ff[DivStages-1];
   assign out_quot  = quot_ff[DivStages-1];
   assign out_ok    = ok_ff[DivStages-1];
endmodule

[rtl/dpgc_checker.sv]
// Port-level checker for the depth colouring block, with its bind.
module dpgc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dpgc_pkg::GrayW-1:0]   rsp_gray_depth,
   input logic [7:0]                   rsp_blue_level,
   input logic [7:0]                   rsp_green_level,
   input logic [7:0]                   rsp_red_level,
   input logic                         rsp_pixel_valid
);
   import dpgc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gray_depth))
      else $error("result item dropped while stalled");

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not track output stall");

   a_invalid_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |-> rsp_gray_depth == '0 && rsp_blue_level == 8'h00
         && rsp_green_level == 8'h00 && rsp_red_level == 8'h00)
      else $error("invalid pixel not black");

   a_zero_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_valid && rsp_gray_depth == '0 |-> rsp_red_level == 8'hFF
         && rsp_green_level == 8'h00 && rsp_blue_level == 8'h00)
      else $error("ramp of zero gray is not red");
endmodule

bind depth_point_to_gray_and_color dpgc_checker u_dpgc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_gray_depth  (rsp_gray_depth),
   .rsp_blue_level  (rsp_blue_level),
   .rsp_green_level (rsp_green_level),
   .rsp_red_level   (rsp_red_level),
   .rsp_pixel_valid (rsp_pixel_valid)
);

[bench/tb.sv]
// Testbench for the depth point to gray and colour ramp block.
module tb;
   import dpgc_pkg::*;

   // Pipeline latency from acceptance to rsp_valid; drain_results adds a margin.
   localparam int PipeLatency = 45;
   localparam int WatchdogLimit = 20000;
   // Register index past the end of the list; writes to it are ignored.
   localparam logic [CsrIdxW-1:0] CsrUnused = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CoordW-1:0] req_coord_x = '0;
   logic signed [CoordW-1:0] req_coord_y = '0;
   logic signed [CoordW-1:0] req_coord_z = '0;
   logic req_z_is_nan = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [GrayW-1:0] rsp_gray_depth;
   logic [7:0] rsp_blue_level, rsp_green_level, rsp_red_level;
   logic rsp_pixel_valid;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;

   typedef struct packed {
      logic [15:0] gray;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic        pix_ok;
   } pixel_type;

   // Shadow copy of the configuration registers.
   logic [15:0] sh_min_mm, sh_max_mm;
   logic        sh_radial, sh_nan_only;
   logic [23:0] sh_bad_z;

   pixel_type pixel_queue[$];
   int  fail_count;
   int  idle_cycles;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_off;

   depth_point_to_gray_and_color i_dut (.*);

   always #2 clock = ~clock;

   // Integer square root, bit by bit on the exact sum of squares.
   function automatic logic [63:0] root_of(input logic [63:0] n);
      logic [63:0] res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n = n - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // Predict the gray value and ramp colour of one point.
   function automatic pixel_type shade_point(input logic signed [23:0] px,
         input logic signed [23:0] py, input logic signed [23:0] pz,
         input logic nan_flag);
      pixel_type p;
      logic signed [63:0] d, lo, hi, sx, sy, sz;
      logic [63:0] g;
      logic [7:0] v;
      logic [31:0] res;
      p = '0;
      if (nan_flag || (!sh_nan_only && pz == $signed(sh_bad_z))) return p;
      sx = px; sy = py; sz = pz;
      if (sh_radial) d = $signed(root_of(sx*sx + sy*sy + sz*sz));
      else d = sz;
      lo = $signed({48'd0, sh_min_mm}) * 256;
      hi = $signed({48'd0, sh_max_mm}) * 256;
      g = 0;
      if (hi > lo) begin
         if (d < lo) d = lo;
         else if (d > hi) d = hi;
         g = (64'(d - lo) * 64'd65535) / 64'(hi - lo);
      end
      p.gray = g[15:0];
      v = p.gray[13:6];
      res = {16'd0, v, 8'hFF};
      if (p.gray[14]) res = (~res >> 8) & 32'hFFFF;
      if (p.gray[15]) res = res << 8;
      p.red = res[7:0];
      p.green = res[15:8];
      p.blue = res[23:16];
      p.pix_ok = 1'b1;
      return p;
   endfunction

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            $error("unexpected result item gray=%0d", rsp_gray_depth);
            fail_count++;
         end else begin
            e = pixel_queue.pop_front();
            if (rsp_gray_depth !== e.gray) begin
               $error("gray_depth expected %0d got %0d", e.gray, rsp_gray_depth);
               fail_count++;
            end
            if (rsp_blue_level !== e.blue) begin
               $error("blue_level expected %0d got %0d", e.blue, rsp_blue_level);
               fail_count++;
            end
            if (rsp_green_level !== e.green) begin
               $error("green_level expected %0d got %0d", e.green, rsp_green_level);
               fail_count++;
            end
            if (rsp_red_level !== e.red) begin
               $error("red_level expected %0d got %0d", e.red, rsp_red_level);
               fail_count++;
            end
            if (rsp_pixel_valid !== e.pix_ok) begin
               $error("pixel_valid expected %0d got %0d", e.pix_ok, rsp_pixel_valid);
               fail_count++;
            end
         end
      end
   end

   // Drive rsp_ready: random stalls, or a long hold-off when asked.
   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one point and hold it until accepted; record its expectation.
   // Valid stays high after acceptance so the next item can follow at once.
   task automatic send_point(input logic signed [23:0] px,
         input logic signed [23:0] py, input logic signed [23:0] pz,
         input logic nan_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= px;
      req_coord_y <= py;
      req_coord_z <= pz;
      req_z_is_nan <= nan_flag;
      pixel_queue.push_back(shade_point(px, py, pz, nan_flag));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PipeLatency + 5) @(posedge clock);
   endtask

   // Write one register while the block is idle; keep the shadow in step.
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CsrMinDepth:   sh_min_mm = val[15:0];
         CsrMaxDepth:   sh_max_mm = val[15:0];
         CsrRadialMode: sh_radial = val[0];
         CsrInvalidNan: sh_nan_only = val[0];
         CsrInvalidZ:   sh_bad_z = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] mn, input logic [15:0] mx,
         input logic rad, input logic nn, input logic [23:0] bz);
      write_reg(CsrMinDepth, {8'd0, mn});
      write_reg(CsrMaxDepth, {8'd0, mx});
      write_reg(CsrRadialMode, {23'd0, rad});
      write_reg(CsrInvalidNan, {23'd0, nn});
      write_reg(CsrInvalidZ, bz);
   endtask

   function automatic logic signed [23:0] rand_coord(input int near_mm);
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($urandom_range(near_mm * 256));
         2: return -24'sd1 * 24'($urandom_range(near_mm * 256));
         default: return 24'($urandom_range(2)) ? 24'h7FFFFF : 24'h800000;
      endcase
   endfunction

   // Extremes of the fields, validity cases and the ramp segments.
   task automatic test_directed();
      int k;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_point(0, 0, 0, 1'b0);           // z equals invalid value
      send_point(0, 0, 24'sd1000, 1'b1);   // NaN flag
      send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
      send_point(24'h800000, 24'h800000, 24'h800000, 1'b0); // negative z
      for (k = 0; k < 8; k++) send_point(0, 0, 24'(k * 600 * 32), 1'b0);
      drain_results();
      configure(16'd100, 16'd50, 1'b1, 1'b1, 24'h800000); // empty range
      send_point(24'sd500, 24'sd7, 0, 1'b0);
      send_point(0, 0, 24'h800000, 1'b0);  // NaN mode ignores the value
      send_point(0, 0, 24'h800000, 1'b1);
      drain_results();
      configure(16'd0, 16'hFFFF, 1'b1, 1'b0, 24'h7FFFFF);
      send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0); // invalid value
      send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE, 1'b0);
      drain_results();
      write_reg(CsrUnused, 24'hFFFFFF);    // unused index, write ignored
      send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE, 1'b0);
      drain_results();
   endtask

   // Random points across several settings and idling phases.
   task automatic test_random();
      int ph, k, near_mm;
      logic signed [23:0] z;
      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (ph == 7) configure(16'hFFFE, 16'hFFFF, 1'(ph), 1'b0, 24'h000100);
         else configure(16'($urandom_range(ph * 4000)),
               16'($urandom_range(ph * 8000 + 900, 300)), 1'($urandom),
               1'($urandom), 24'($urandom));
         near_mm = (sh_max_mm > 32000) ? 32000 : sh_max_mm + 10;
         for (k = 0; k < 65; k++) begin
            z = rand_coord(near_mm);
            if ($urandom_range(9) == 0) z = sh_bad_z;
            send_point(rand_coord(near_mm), rand_coord(near_mm), z,
                  ($urandom_range(9) == 0));
         end
         drain_results();
      end
   endtask

   // Hold the receiver off so the pipe fills and req_ready drops.
   task automatic test_backpressure();
      int k;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         for (k = 0; k < 60; k++)
            send_point(rand_coord(700), rand_coord(700), rand_coord(700), 1'b0);
      join
      drain_results();
   endtask

   initial begin
      fail_count = 0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      sh_min_mm = 16'd0;
      sh_max_mm = MaxDepthReset;
      sh_radial = 1'b0;
      sh_nan_only = 1'b0;
      sh_bad_z = 24'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
